>>> hw/rtl/reply_trace_filter_ack_detect_top_defines.svh
// Assertion helpers shared by the RTL of the reply trace filter.
`ifndef REPLY_TRACE_FILTER_ACK_DETECT_TOP_DEFINES_SVH
`define REPLY_TRACE_FILTER_ACK_DETECT_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside of reset.
`define RTFAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtfad same-cycle assertion failed");

// Next-cycle implication, checked at every rising edge outside of reset.
`define RTFAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtfad next-cycle assertion failed");

`endif

>>> hw/rtl/rtfad_pkg.sv
package rtfad_pkg;

    typedef logic [10:0] t_count;
    typedef logic [7:0]  t_byte;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_FILTER = 2'd1;
    localparam logic [1:0] KIND_RAW    = 2'd2;

    // Chunk status codes.
    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_ACK  = 2'd1;
    localparam logic [1:0] STAT_NAK  = 2'd2;

    localparam t_count CAP_RESET = 11'd1024;

    // Characters of interest.
    localparam t_byte CH_BANG  = 8'h21;
    localparam t_byte CH_QUOTE = 8'h22;
    localparam t_byte CH_QMARK = 8'h3F;
    localparam t_byte CH_PCT   = 8'h25;
    localparam t_byte CH_BSL   = 8'h5C;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_ENQ   = 8'h05;
    localparam t_byte CH_STX   = 8'h02;
    localparam t_byte CH_ETX   = 8'h03;
    localparam t_byte CH_ETB   = 8'h17;

    // Control characters expand to five-character tags.
    localparam int TAG_LEN = 5;
    localparam logic [1:0] TAG_ENQ = 2'd0;
    localparam logic [1:0] TAG_STX = 2'd1;
    localparam logic [1:0] TAG_ETX = 2'd2;
    localparam logic [1:0] TAG_ETB = 2'd3;

    localparam t_byte TAG_TEXT [4][TAG_LEN] = '{
        '{8'h5B, 8'h45, 8'h4E, 8'h51, 8'h5D},   // [ENQ]
        '{8'h5B, 8'h53, 8'h54, 8'h58, 8'h5D},   // [STX]
        '{8'h5B, 8'h45, 8'h54, 8'h58, 8'h5D},   // [ETX]
        '{8'h5B, 8'h45, 8'h54, 8'h42, 8'h5D}    // [ETB]
    };

    typedef struct packed {
        logic [1:0] kind;
        t_byte      data_byte;
        logic       chunk_end;
    } t_item;

    // Everything the emitter needs to play out the results of one word.
    typedef struct packed {
        logic [TAG_LEN-1:0][7:0] chars;       // chars[0] goes out first
        logic                    has_char;
        logic [2:0]              left;        // results to send, 1 to 5
        t_count                  first_count; // count after the first result
        t_byte                   first_char;
        logic [1:0]              status;
        logic                    chunk_end;
    } t_plan;

endpackage

>>> hw/rtl/rtfad_in_if.sv
interface rtfad_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source(output valid, output kind, output data_byte, output chunk_end, input ready);
    modport sink(input valid, input kind, input data_byte, input chunk_end, output ready);
endinterface

>>> hw/rtl/rtfad_out_if.sv
interface rtfad_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_out;
    logic        char_valid;
    logic [1:0]  chunk_status;
    logic        status_valid;
    logic        last;
    logic [10:0] stored_count;
    logic        lone_backslash;

    modport source(
        output valid, output char_out, output char_valid, output chunk_status,
        output status_valid, output last, output stored_count, output lone_backslash,
        input ready
    );
    modport sink(
        input valid, input char_out, input char_valid, input chunk_status,
        input status_valid, input last, input stored_count, input lone_backslash,
        output ready
    );
endinterface

>>> hw/rtl/reply_trace_filter_ack_detect_top.sv
// Reply trace filter with acknowledge detection.
//
// Words enter on i_in (kind, data_byte, chunk_end) and results leave on o_out, both
// valid/ready channels; a word moves at an edge where valid and ready are both high.
// The user writes the capacity register (i_cfg_we/i_cfg_wdata) only while idle; unchecked.
//
// Each input word is registered, decoded in one pass against the trace state and
// handed to an output stage that plays out its results, one result word per cycle while
// o_out.ready is high. A word yields one to five result words (a control character
// expands to a tag of up to five characters) and holds the output stage until its last
// result leaves; words that give one result flow at one per cycle while o_out.ready is
// high. The first result of a word passes the input register and the output stage's
// register before it shows on o_out; its one-result-per-cycle port sets the rate.
//
// Reset (synchronous, i_rst_n low) empties both stages, clears the count, quote
// flag, first character and chunk status, and sets capacity to 1024.
// When o_out.ready is low the result word holds; the input register still takes one
// more word, then i_in.ready drops until the output stage moves on.
module reply_trace_filter_ack_detect_top #(
    parameter int MAX_BUFFER = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtfad_in_if.sink          i_in,
    rtfad_out_if.source       o_out,
    input  logic              i_cfg_we,
    input  rtfad_pkg::t_count i_cfg_wdata
);
    import rtfad_pkg::*;

`include "reply_trace_filter_ack_detect_top_defines.svh"

    logic  plan_valid;
    logic  plan_ready;
    t_plan plan;

    // Decoder: input register, capacity register and trace state.
    rtfad_decode #(
        .MAX_BUFFER(MAX_BUFFER)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in         (i_in),
        .i_plan_ready (plan_ready),
        .o_plan_valid (plan_valid),
        .o_plan       (plan)
    );

    // Output stage: plays out the characters of one decoded word.
    rtfad_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .i_plan       (plan),
        .o_plan_ready (plan_ready),
        .o_out        (o_out)
    );

    // Chunk status is only reported on the final result of a word.
    `RTFAD_ASSERT_NOW(a_status_on_last, i_clk, i_rst_n, o_out.valid && o_out.status_valid, o_out.last)

    // A result without a character is always the only result of its word.
    `RTFAD_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, o_out.valid && !o_out.char_valid, o_out.last)

    // A status code shows up only with its status flag.
    `RTFAD_ASSERT_NOW(a_status_flagged, i_clk, i_rst_n, o_out.valid && (o_out.chunk_status != STAT_NONE), o_out.status_valid)

    // Within one word, each further character advances the count by one.
    `RTFAD_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last, o_out.valid && (o_out.stored_count == $past(o_out.stored_count) + 11'd1))

endmodule

>>> hw/rtl/rtfad_decode.sv
module rtfad_decode #(
    parameter int MAX_BUFFER = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  rtfad_pkg::t_count i_cfg_wdata,
    rtfad_in_if.sink          i_in,
    input  logic              i_plan_ready,
    output logic              o_plan_valid,
    output rtfad_pkg::t_plan  o_plan
);
    import rtfad_pkg::*;

    // Capacity limit folded to the 11-bit count range.
    localparam t_count MAX_CAP = (MAX_BUFFER > 2047) ? 11'd2047 : 11'(MAX_BUFFER);

    logic       r_in_valid;
    t_item      r_item;
    t_count     r_capacity;
    t_count     r_count;
    logic       r_in_quotes;
    t_byte      r_first_char;
    logic [1:0] r_pending;
    logic       r_halted;

    t_count     n_count;
    logic       n_in_quotes;
    t_byte      n_first_char;
    logic [1:0] n_pending;
    logic       n_halted;

    t_count     eff_cap;
    t_count     cap_diff;
    logic       has_room;
    logic [2:0] tag_n;
    logic [2:0] n_chars;
    logic [TAG_LEN-1:0][7:0] chars;
    t_byte      b;
    logic       take;

    assign take         = r_in_valid && i_plan_ready;
    assign i_in.ready   = !r_in_valid || i_plan_ready;
    assign o_plan_valid = r_in_valid;

    assign eff_cap  = (r_capacity > MAX_CAP) ? MAX_CAP : r_capacity;
    assign has_room = r_count < eff_cap;
    assign cap_diff = eff_cap - r_count;
    assign tag_n    = (cap_diff >= 11'd5) ? 3'd5 : cap_diff[2:0];
    assign b        = r_item.data_byte;

    always_comb begin
        n_count      = r_count;
        n_in_quotes  = r_in_quotes;
        n_first_char = r_first_char;
        n_pending    = r_pending;
        n_halted     = r_halted;
        n_chars      = 3'd0;
        chars        = '0;

        case (r_item.kind)
            KIND_CLEAR: begin
                n_count      = '0;
                n_in_quotes  = 1'b0;
                n_first_char = '0;
            end
            KIND_FILTER: begin
                if (!r_halted) begin
                    if (!has_room) begin
                        // Full buffer: only scan for quotes and acknowledges.
                        if (r_pending == STAT_NONE) begin
                            if (b == CH_BANG) begin
                                if (!r_in_quotes) begin
                                    n_pending = STAT_ACK;
                                end
                            end else if (b == CH_QUOTE) begin
                                n_in_quotes = !r_in_quotes;
                            end else if ((b inside {CH_QMARK, CH_PCT}) && r_count == '0
                                         && !r_in_quotes) begin
                                n_pending = STAT_NAK;
                            end
                        end
                    end else if (b == CH_BANG) begin
                        if (!r_in_quotes) begin
                            n_pending = STAT_ACK;
                            n_halted  = 1'b1;
                        end else begin
                            n_chars  = 3'd1;
                            chars[0] = b;
                        end
                    end else if (b == CH_QUOTE) begin
                        n_in_quotes = !r_in_quotes;
                        n_chars     = 3'd1;
                        chars[0]    = b;
                    end else if (b inside {CH_ENQ, CH_STX, CH_ETX, CH_ETB}) begin
                        n_chars = tag_n;
                        for (int i = 0; i < TAG_LEN; i++) begin
                            case (b)
                                CH_ENQ:  chars[i] = TAG_TEXT[TAG_ENQ][i];
                                CH_STX:  chars[i] = TAG_TEXT[TAG_STX][i];
                                CH_ETX:  chars[i] = TAG_TEXT[TAG_ETX][i];
                                default: chars[i] = TAG_TEXT[TAG_ETB][i];
                            endcase
                        end
                        if (b == CH_ETX) begin
                            n_pending = STAT_ACK;
                        end
                    end else if (b inside {CH_LF, CH_CR}) begin
                        n_chars  = 3'd1;
                        chars[0] = CH_SPACE;
                    end else begin
                        if ((b inside {CH_QMARK, CH_PCT}) && r_count == '0 && !r_in_quotes) begin
                            n_pending = STAT_NAK;
                        end
                        n_chars  = 3'd1;
                        chars[0] = b;
                    end
                end
            end
            KIND_RAW: begin
                if (has_room) begin
                    n_chars  = 3'd1;
                    chars[0] = b;
                end
            end
            default: begin
            end
        endcase

        if (n_chars != 3'd0) begin
            n_count = r_count + 11'(n_chars);
            if (r_count == '0) begin
                n_first_char = chars[0];
            end
        end
    end

    always_comb begin
        o_plan.chars       = chars;
        o_plan.has_char    = n_chars != 3'd0;
        o_plan.left        = (n_chars != 3'd0) ? n_chars : 3'd1;
        o_plan.first_count = (n_chars != 3'd0) ? r_count + 11'd1 : n_count;
        o_plan.first_char  = n_first_char;
        o_plan.status      = n_pending;
        o_plan.chunk_end   = r_item.chunk_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_capacity   <= CAP_RESET;
            r_count      <= '0;
            r_in_quotes  <= 1'b0;
            r_first_char <= '0;
            r_pending    <= STAT_NONE;
            r_halted     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take) begin
                r_count      <= n_count;
                r_in_quotes  <= n_in_quotes;
                r_first_char <= n_first_char;
                r_pending    <= r_item.chunk_end ? STAT_NONE : n_pending;
                r_halted     <= r_item.chunk_end ? 1'b0 : n_halted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.kind      <= i_in.kind;
            r_item.data_byte <= i_in.data_byte;
            r_item.chunk_end <= i_in.chunk_end;
        end
    end

endmodule

>>> hw/rtl/rtfad_emit.sv
module rtfad_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_plan_valid,
    input  rtfad_pkg::t_plan i_plan,
    output logic             o_plan_ready,
    rtfad_out_if.source      o_out
);
    import rtfad_pkg::*;

    logic                    r_valid;
    logic [TAG_LEN-1:0][7:0] r_chars;
    logic                    r_has_char;
    logic [2:0]              r_left;
    t_count                  r_count;
    t_byte                   r_first_char;
    logic [1:0]              r_status;
    logic                    r_end;

    logic at_last;

    assign at_last      = r_left == 3'd1;
    assign o_plan_ready = !r_valid || (o_out.ready && at_last);

    assign o_out.valid          = r_valid;
    assign o_out.char_out       = r_chars[0];
    assign o_out.char_valid     = r_has_char;
    assign o_out.last           = at_last;
    assign o_out.status_valid   = at_last && r_end;
    assign o_out.chunk_status   = (at_last && r_end) ? r_status : STAT_NONE;
    assign o_out.stored_count   = r_count;
    assign o_out.lone_backslash = (r_count == 11'd1) && (r_first_char == CH_BSL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_plan_valid && o_plan_ready) begin
            r_valid <= 1'b1;
        end else if (r_valid && o_out.ready && at_last) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload: load a new plan, or step to the next tag character.
    always_ff @(posedge i_clk) begin
        if (i_plan_valid && o_plan_ready) begin
            r_chars      <= i_plan.chars;
            r_has_char   <= i_plan.has_char;
            r_left       <= i_plan.left;
            r_count      <= i_plan.first_count;
            r_first_char <= i_plan.first_char;
            r_status     <= i_plan.status;
            r_end        <= i_plan.chunk_end;
        end else if (r_valid && o_out.ready && !at_last) begin
            r_chars <= r_chars >> 8;
            r_left  <= r_left - 3'd1;
            r_count <= r_count + 11'd1;
        end
    end

endmodule

>>> dv/reply_trace_filter_ack_detect_top_tb.sv
`timescale 1ns / 1ps

module reply_trace_filter_ack_detect_top_tb;
    import rtfad_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_BUF     = 1024;
    // Tail waited out after the last result in case the block is still busy.
    localparam int DRAIN_TAIL  = 10;
    // Cycles with no word moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;

    // The package leaves the fourth kind unnamed; the block must still treat it as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Bytes that steer the filter, drawn often so that the special paths get exercised.
    localparam int N_SPECIAL = 11;
    localparam t_byte SPECIAL_BYTES [N_SPECIAL] = '{
        CH_BANG, CH_QUOTE, CH_QMARK, CH_PCT, CH_BSL, CH_LF, CH_CR,
        CH_ENQ, CH_STX, CH_ETX, CH_ETB
    };

    // One result word as it should appear on the output channel.
    typedef struct packed {
        t_byte      ch;
        logic       ch_valid;
        logic [1:0] status;
        logic       status_valid;
        logic       last;
        t_count     count;
        logic       lone;
    } t_trace_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_count i_cfg_wdata;

    rtfad_in_if  in_if ();
    rtfad_out_if out_if ();

    reply_trace_filter_ack_detect_top #(
        .MAX_BUFFER (MAX_BUF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle and stall rates in percent, changed between test phases.
    int src_idle_pct;
    int snk_stall_pct;
    int err_count;
    int quiet_cycles;

    // Trace state as the block should hold it.
    int unsigned trc_cap;
    int unsigned trc_count;
    bit          trc_quoted;
    t_byte       trc_first;
    logic [1:0]  trc_pending;
    bit          trc_halted;

    // Results of the word being predicted, and all results still owed by the block.
    t_trace_res word_res[$];
    t_trace_res trace_expected[$];

    // ------------------------------------------------------------------
    // Trace predictor
    // ------------------------------------------------------------------

    // The capacity actually in force is clamped to the synthesized buffer size.
    function automatic int unsigned trace_limit();
        return (trc_cap > MAX_BUF) ? MAX_BUF : trc_cap;
    endfunction

    function automatic logic trace_lone();
        return (trc_count == 1) && (trc_first == CH_BSL);
    endfunction

    // Appends one character if there is room, both in the buffer and in the
    // five result words that one input word may produce.
    task automatic trace_store(input t_byte c);
        t_trace_res r;
        if (word_res.size() >= TAG_LEN || trc_count >= trace_limit())
            return;
        if (trc_count == 0)
            trc_first = c;
        trc_count++;
        r              = '0;
        r.ch           = c;
        r.ch_valid     = 1'b1;
        r.count        = t_count'(trc_count);
        r.lone         = trace_lone();
        word_res.push_back(r);
    endtask

    // Tags are cut short when the buffer fills part way through.
    task automatic trace_tag(input logic [1:0] which);
        for (int i = 0; i < TAG_LEN && trc_count < trace_limit(); i++)
            trace_store(TAG_TEXT[which][i]);
    endtask

    task automatic trace_filter(input t_byte b);
        if (trc_halted)
            return;
        if (trc_count >= trace_limit()) begin
            // Full buffer: only quotes and acknowledges are looked at, and only
            // until a status is known. A quote here does not swallow the next byte.
            if (trc_pending != STAT_NONE)
                return;
            if (b == CH_BANG) begin
                if (!trc_quoted)
                    trc_pending = STAT_ACK;
            end else if (b == CH_QUOTE) begin
                trc_quoted = !trc_quoted;
            end else if ((b == CH_QMARK || b == CH_PCT) && trc_count == 0) begin
                if (!trc_quoted)
                    trc_pending = STAT_NAK;
            end
            return;
        end
        if (b == CH_BANG) begin
            if (!trc_quoted) begin
                trc_pending = STAT_ACK;
                trc_halted  = 1'b1;
            end else begin
                trace_store(b);
            end
        end else if (b == CH_QUOTE) begin
            trc_quoted = !trc_quoted;
            trace_store(b);
        end else if (b == CH_ENQ) begin
            trace_tag(TAG_ENQ);
        end else if (b == CH_STX) begin
            trace_tag(TAG_STX);
        end else if (b == CH_ETX) begin
            trace_tag(TAG_ETX);
            trc_pending = STAT_ACK;
        end else if (b == CH_ETB) begin
            trace_tag(TAG_ETB);
        end else if (b == CH_LF || b == CH_CR) begin
            trace_store(CH_SPACE);
        end else begin
            if ((b == CH_QMARK || b == CH_PCT) && trc_count == 0 && !trc_quoted)
                trc_pending = STAT_NAK;
            trace_store(b);
        end
    endtask

    // Works out every result word of one accepted input word and queues them.
    task automatic trace_predict(input logic [1:0] kind, input t_byte b, input logic cend);
        t_trace_res r;
        word_res.delete();
        if (kind == KIND_CLEAR) begin
            trc_count  = 0;
            trc_quoted = 1'b0;
            trc_first  = '0;
        end else if (kind == KIND_FILTER) begin
            trace_filter(b);
        end else if (kind == KIND_RAW) begin
            trace_store(b);
        end
        // A word that stores nothing still yields one empty result.
        if (word_res.size() == 0) begin
            r       = '0;
            r.count = t_count'(trc_count);
            r.lone  = trace_lone();
            word_res.push_back(r);
        end
        r      = word_res[$];
        r.last = 1'b1;
        if (cend) begin
            r.status     = trc_pending;
            r.status_valid = 1'b1;
            trc_pending  = STAT_NONE;
            trc_halted   = 1'b0;
        end
        word_res[$] = r;
        foreach (word_res[i])
            trace_expected.push_back(word_res[i]);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result checker
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Every result word is compared against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_trace_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (trace_expected.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("unexpected result word: ch=%h cv=%b st=%0d sv=%b last=%b cnt=%0d",
                             out_if.char_out, out_if.char_valid, out_if.chunk_status,
                             out_if.status_valid, out_if.last, out_if.stored_count);
            end else begin
                want = trace_expected.pop_front();
                if (out_if.char_out !== want.ch || out_if.char_valid !== want.ch_valid ||
                    out_if.chunk_status !== want.status ||
                    out_if.status_valid !== want.status_valid ||
                    out_if.last !== want.last || out_if.stored_count !== want.count ||
                    out_if.lone_backslash !== want.lone) begin
                    err_count++;
                    if (err_count <= REPORT_MAX) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected ch=%h cv=%b st=%0d sv=%b last=%b cnt=%0d lone=%b",
                                 want.ch, want.ch_valid, want.status, want.status_valid,
                                 want.last, want.count, want.lone);
                        $display("  actual   ch=%h cv=%b st=%0d sv=%b last=%b cnt=%0d lone=%b",
                                 out_if.char_out, out_if.char_valid, out_if.chunk_status,
                                 out_if.status_valid, out_if.last, out_if.stored_count,
                                 out_if.lone_backslash);
                    end
                end
            end
        end
    end

    // The watchdog restarts whenever a word moves on either channel.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("reply_trace_filter_ack_detect_top_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Presents one word from a falling edge and holds it until the block takes it.
    // Valid is left high after the handshake; the next call or settle() decides
    // at the following falling edge whether it carries a new word or drops.
    task automatic send_word(input logic [1:0] kind, input t_byte b, input logic cend);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.data_byte <= b;
        in_if.chunk_end <= cend;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        trace_predict(kind, b, cend);
    endtask

    // Stops the sender and waits until every owed result has come back.
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (trace_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // The capacity register may only change while the block is idle.
    task automatic set_capacity(input int unsigned value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_count'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        trc_cap = value;
    endtask

    // Half of the bytes come from the steering set, the rest are uniform.
    function automatic t_byte pick_byte();
        if ($urandom_range(99) < 50)
            return SPECIAL_BYTES[$urandom_range(N_SPECIAL - 1)];
        return t_byte'($urandom_range(255));
    endfunction

    // One reply chunk with random content; it often starts from an empty buffer
    // so that a leading question mark or percent sign can be seen.
    task automatic send_chunk(output int n_words);
        int         len;
        int         pick;
        logic [1:0] kind;
        len     = $urandom_range(1, 8);
        n_words = len;
        if ($urandom_range(99) < 20) begin
            send_word(KIND_CLEAR, pick_byte(), 1'b0);
            n_words++;
        end
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                kind = KIND_CLEAR;
            else if (pick < 25)
                kind = KIND_RAW;
            else
                kind = KIND_FILTER;
            send_word(kind, pick_byte(), i == len - 1);
        end
    endtask

    // Mostly small capacities so that the buffer fills and the full-buffer scan
    // is reached; now and then the extremes.
    function automatic int unsigned pick_capacity();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 0;
        if (pick < 50)
            return $urandom_range(1, 20);
        if (pick < 88)
            return $urandom_range(21, 80);
        return MAX_BUF;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation and every special case once, at the reset capacity.
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // A leading question mark or percent sign is a negative acknowledge.
        send_word(KIND_FILTER, CH_QMARK, 1'b1);
        send_word(KIND_CLEAR, 8'hFF, 1'b0);
        send_word(KIND_FILTER, CH_PCT, 1'b1);
        send_word(KIND_CLEAR, 8'h00, 1'b0);
        // A lone backslash raises the flag; a second character clears it.
        send_word(KIND_RAW, CH_BSL, 1'b0);
        send_word(KIND_RAW, 8'h00, 1'b0);
        // Inside quotes the bang and question mark are plain text.
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b0);
        send_word(KIND_FILTER, CH_QMARK, 1'b0);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_CR, 1'b0);
        send_word(KIND_FILTER, CH_LF, 1'b0);
        send_word(KIND_FILTER, CH_ENQ, 1'b0);
        send_word(KIND_FILTER, CH_STX, 1'b0);
        send_word(KIND_FILTER, CH_ETB, 1'b0);
        // End of text reports at the chunk end but storing continues.
        send_word(KIND_FILTER, CH_ETX, 1'b0);
        send_word(KIND_FILTER, 8'h41, 1'b1);
        // A bang outside quotes halts the rest of the chunk.
        send_word(KIND_FILTER, CH_BANG, 1'b0);
        send_word(KIND_FILTER, 8'h42, 1'b0);
        send_word(KIND_FILTER, CH_ETX, 1'b1);
        send_word(KIND_RAW, 8'hFF, 1'b0);
        // A clear keeps the chunk status and can close the chunk.
        send_word(KIND_FILTER, CH_BANG, 1'b0);
        send_word(KIND_CLEAR, 8'h5A, 1'b1);
        // A later acknowledge replaces an earlier negative one.
        send_word(KIND_FILTER, CH_QMARK, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b1);
        send_word(KIND_UNUSED, 8'h55, 1'b1);
        send_word(KIND_FILTER, 8'hFF, 1'b1);
    endtask

    // Capacity extremes, tag truncation and lowering the capacity below the count.
    task automatic test_small_capacity();
        set_capacity(0);
        // With no room and a nonzero count, a question mark is ignored by the scan.
        send_word(KIND_FILTER, CH_QMARK, 1'b1);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b1);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b0);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, 8'h78, 1'b1);
        // Two quotes in a row must both count during the scan.
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b1);
        send_word(KIND_RAW, 8'h61, 1'b1);

        set_capacity(3);
        send_word(KIND_CLEAR, 8'h00, 1'b0);
        send_word(KIND_FILTER, 8'h41, 1'b0);
        send_word(KIND_FILTER, CH_ENQ, 1'b0);
        send_word(KIND_FILTER, CH_CR, 1'b1);

        set_capacity(7);
        send_word(KIND_FILTER, CH_STX, 1'b1);

        // Below the current count nothing more is stored and the count stays.
        set_capacity(1);
        send_word(KIND_RAW, 8'h7A, 1'b1);
        send_word(KIND_FILTER, CH_BANG, 1'b1);
        send_word(KIND_CLEAR, 8'h00, 1'b0);
        send_word(KIND_RAW, CH_BSL, 1'b0);
        send_word(KIND_FILTER, CH_QMARK, 1'b1);

        set_capacity(MAX_BUF);
    endtask

    // Fills the largest buffer with tags under heavy back-pressure, then scans.
    task automatic test_full_buffer();
        snk_stall_pct = 83;
        send_word(KIND_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < MAX_BUF / TAG_LEN + 1; i++)
            send_word(KIND_FILTER, CH_ENQ, $urandom_range(7) == 0);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b0);
        send_word(KIND_FILTER, CH_QUOTE, 1'b0);
        send_word(KIND_FILTER, CH_BANG, 1'b1);
        send_word(KIND_RAW, 8'h80, 1'b1);
        settle();
        snk_stall_pct = 0;
    endtask

    // Random chunks in three capacity settings under one idle pattern.
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_words);
        int sent;
        int n;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int blk = 0; blk < 3; blk++) begin
            set_capacity(pick_capacity());
            sent = 0;
            while (sent < n_words / 3) begin
                send_chunk(n);
                sent += n;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_CLEAR;
        in_if.data_byte = '0;
        in_if.chunk_end = 1'b0;
        out_if.ready    = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        err_count       = 0;
        quiet_cycles    = 0;

        trc_cap     = CAP_RESET;
        trc_count   = 0;
        trc_quoted  = 1'b0;
        trc_first   = '0;
        trc_pending = STAT_NONE;
        trc_halted  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_small_capacity();
        test_full_buffer();
        test_random_traffic(0, 0, 45);
        test_random_traffic(83, 0, 42);
        test_random_traffic(0, 83, 42);
        test_random_traffic(24, 24, 42);
        set_capacity(MAX_BUF);
        settle();

        if (err_count == 0)
            $display("reply_trace_filter_ack_detect_top_tb OK");
        else
            $display("reply_trace_filter_ack_detect_top_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rtfad_pkg.sv
hw/rtl/rtfad_in_if.sv
hw/rtl/rtfad_out_if.sv
hw/rtl/rtfad_decode.sv
hw/rtl/rtfad_emit.sv
hw/rtl/reply_trace_filter_ack_detect_top.sv
dv/reply_trace_filter_ack_detect_top_tb.sv
